FILE: design/rsm_pkg.sv
`timescale 1ns / 1ps

package rsm_pkg;

    // Fixed field widths
    localparam int VEL_W   = 16;
    localparam int RATIO_W = 24;
    localparam int SUM_W   = 64;
    localparam int FRAC_W  = 16;   // fractional bits of a Q8.16 ratio
    localparam int INT_W   = 8;    // integer bits of a Q8.16 ratio

    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    typedef struct packed {
        logic [VEL_W-1:0] ref_velocity;
        logic [VEL_W-1:0] trial_velocity;
        logic             last_cell;
    } rsm_cell_t;

    typedef struct packed {
        logic [RATIO_W-1:0] l1_ratio;
        logic [RATIO_W-1:0] l2_ratio;
        logic               saturated;
    } rsm_norm_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_REF,
        S_WAIT_REF,
        S_DIV_TRIAL,
        S_WAIT_TRIAL,
        S_DIFF,
        S_MUL_DIFF,
        S_MUL_REF,
        S_ACCUM,
        S_DIV_L1,
        S_WAIT_L1,
        S_DIV_L2,
        S_WAIT_L2,
        S_OUT
    } rsm_state_t;

    // What the shared divider is working on
    typedef enum logic [1:0] {
        DIV_REF,
        DIV_TRIAL,
        DIV_L1,
        DIV_L2
    } rsm_div_sel_t;

    typedef struct packed {
        logic         load_cell;
        logic         div_start;
        rsm_div_sel_t div_sel;
        logic         cap_quot;
        logic         calc_diff;
        logic         mul_diff;
        logic         mul_ref;
        logic         accum;
        logic         out_load;
    } rsm_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic last_cell;
        logic out_blocked;
    } rsm_status_t;

endpackage

FILE: design/relative_slowness_misfit_norms.sv
// Each cell needs two reciprocals of SLOWNESS_FRAC_BITS + 1 steps each in the shared
// radix-2 divider. A last cell adds two 24-step ratio divisions before the result
// beat lands in the output register; the next cell is taken while that beat waits.
// rst_n is asynchronous, active low: it idles the controller and clears all sums.
`timescale 1ns / 1ps

module relative_slowness_misfit_norms #(
    parameter int SLOWNESS_FRAC_BITS = 24,
    parameter int VELOCITY_BITS      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cell_valid,
    output logic               cell_stall,
    input  rsm_pkg::rsm_cell_t cell_data,
    output logic               norm_valid,
    input  logic               norm_stall,
    output rsm_pkg::rsm_norm_t norm
);
    import rsm_pkg::*;

    rsm_cmd_t    cmd;
    rsm_status_t status;
    rsm_state_t  state;

    rsm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .status     (status),
        .cmd        (cmd),
        .state      (state)
    );

    rsm_datapath #(
        .SLOWNESS_FRAC_BITS (SLOWNESS_FRAC_BITS),
        .VELOCITY_BITS      (VELOCITY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_data  (cell_data),
        .norm_stall (norm_stall),
        .cmd        (cmd),
        .status     (status),
        .norm       (norm),
        .norm_valid (norm_valid)
    );

    // Divider is never restarted mid-division
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // A new result beat only follows the output state
    a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(norm_valid) |-> $past(state) == S_OUT)
        else $error("result beat raised outside output state");

    // A cell is taken only while nothing is in flight in the divider
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall) |=> state == S_DIV_REF && !status.div_busy)
        else $error("cell accepted while busy");

endmodule

FILE: design/rsm_div.sv
`timescale 1ns / 1ps

module rsm_div #(
    parameter int LW    = 25,
    parameter int CNT_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [CNT_W-1:0]           iters,
    input  logic [rsm_pkg::SUM_W-1:0]  rem_init,
    input  logic [LW-1:0]              low_init,
    input  logic [rsm_pkg::SUM_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [LW-1:0]              quot
);
    import rsm_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [LW-1:0]    low_reg;
    logic [LW-1:0]    quot_reg;

    logic [SUM_W:0]   partial;
    logic             fits;
    logic [SUM_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign partial  = {rem_reg, low_reg[LW-1]};
    assign fits     = partial >= {1'b0, den_reg};
    assign rem_next = fits ? SUM_W'(partial - {1'b0, den_reg}) : partial[SUM_W-1:0];

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= iters;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            den_reg  <= divisor;
            low_reg  <= low_init;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[LW-2:0], 1'b0};
            quot_reg <= {quot_reg[LW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: design/rsm_datapath.sv
`timescale 1ns / 1ps

module rsm_datapath #(
    parameter int SLOWNESS_FRAC_BITS = 24,
    parameter int VELOCITY_BITS      = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsm_pkg::rsm_cell_t   cell_data,
    input  logic                 norm_stall,
    input  rsm_pkg::rsm_cmd_t    cmd,
    output rsm_pkg::rsm_status_t status,
    output rsm_pkg::rsm_norm_t   norm,
    output logic                 norm_valid
);
    import rsm_pkg::*;

    localparam int SW       = SLOWNESS_FRAC_BITS + 1;            // slowness width
    localparam int SQ_SHIFT = 2 * SLOWNESS_FRAC_BITS - 32;
    localparam int SQ_W     = 2 * SW - SQ_SHIFT;                 // Q2.32 square width
    localparam int LW       = (SW > RATIO_W) ? SW : RATIO_W;     // divider dividend width
    localparam int CNT_W    = $clog2(LW + 1);
    localparam int VM       = (VELOCITY_BITS < VEL_W) ? VELOCITY_BITS : VEL_W;
    localparam logic [VEL_W-1:0] VEL_MASK = VEL_W'((64'd1 << VM) - 64'd1);

    logic [VEL_W-1:0]   vref_reg;
    logic [VEL_W-1:0]   vtrial_reg;
    logic               last_reg;
    logic [SW-1:0]      sref_reg;
    logic [SW-1:0]      strial_reg;
    logic [SW-1:0]      diff_reg;
    logic [SQ_W-1:0]    prod_reg;
    logic [SQ_W-1:0]    sqdiff_reg;
    logic [SUM_W-1:0]   sum_abs_reg;
    logic [SUM_W-1:0]   sum_sq_reg;
    logic [SUM_W-1:0]   sum_ref_reg;
    logic [SUM_W-1:0]   sum_refsq_reg;
    rsm_div_sel_t       sel_reg;
    logic               rz_reg;
    logic               rs_reg;
    logic [RATIO_W-1:0] l1_reg;
    logic               l1_sat_reg;
    logic [RATIO_W-1:0] l2_reg;
    logic               l2_sat_reg;
    rsm_norm_t          norm_reg;
    logic               norm_valid_reg;

    logic [VEL_W-1:0]   vel_sel;
    logic [VEL_W-1:0]   vel_masked;
    logic [SUM_W-1:0]   num;
    logic [SUM_W-1:0]   den;
    logic [CNT_W-1:0]   div_iters;
    logic [SUM_W-1:0]   div_rem_init;
    logic [LW-1:0]      div_low_init;
    logic [SUM_W-1:0]   div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [LW-1:0]      div_quot;
    logic               num_zero;
    logic               den_zero;
    logic               too_big;
    logic [RATIO_W-1:0] ratio_val;
    logic               ratio_sat;
    logic [SW-1:0]      mul_a;
    logic [2*SW-1:0]    mul_full;
    logic [SQ_W-1:0]    sq_val;

    // Divider operand selection
    always_comb
    begin
        vel_sel    = (cmd.div_sel == DIV_TRIAL) ? vtrial_reg : vref_reg;
        vel_masked = vel_sel & VEL_MASK;
        num        = (cmd.div_sel == DIV_L2) ? sum_sq_reg : sum_abs_reg;
        den        = (cmd.div_sel == DIV_L2) ? sum_refsq_reg : sum_ref_reg;
        case (cmd.div_sel)
            DIV_REF, DIV_TRIAL:
            begin
                div_iters    = CNT_W'(SW);
                div_rem_init = '0;
                div_low_init = LW'(1) << (LW - 1);
                // zero velocity counts as one
                div_divisor  = (vel_masked == '0) ? SUM_W'(1) : SUM_W'(vel_masked);
            end
            default:
            begin
                // integer part known below 256: start from num >> 8
                div_iters    = CNT_W'(RATIO_W);
                div_rem_init = SUM_W'(num >> INT_W);
                div_low_init = LW'({num[INT_W-1:0], {FRAC_W{1'b0}}}) << (LW - RATIO_W);
                div_divisor  = den;
            end
        endcase
        num_zero = (num == '0);
        den_zero = (den == '0);
        too_big  = {{INT_W{1'b0}}, num} >= {den, {INT_W{1'b0}}};
    end

    rsm_div #(
        .LW    (LW),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .iters    (div_iters),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Ratio result with zero-divisor and clipping cases
    always_comb
    begin
        ratio_sat = rs_reg;
        if (rz_reg)
            ratio_val = '0;
        else if (rs_reg)
            ratio_val = RATIO_MAX;
        else
            ratio_val = div_quot[RATIO_W-1:0];
    end

    // Shared squarer, Q2.32 result
    assign mul_a    = cmd.mul_ref ? sref_reg : diff_reg;
    assign mul_full = (2*SW)'(mul_a) * (2*SW)'(mul_a);
    assign sq_val   = SQ_W'(mul_full >> SQ_SHIFT);

    // Per-cell payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_cell)
        begin
            vref_reg   <= cell_data.ref_velocity;
            vtrial_reg <= cell_data.trial_velocity;
            last_reg   <= cell_data.last_cell;
        end
        if (cmd.div_start)
        begin
            sel_reg <= cmd.div_sel;
            rz_reg  <= den_zero && num_zero;
            rs_reg  <= den_zero ? !num_zero : too_big;
        end
        if (cmd.cap_quot)
        begin
            case (sel_reg)
                DIV_REF:   sref_reg   <= div_quot[SW-1:0];
                DIV_TRIAL: strial_reg <= div_quot[SW-1:0];
                DIV_L1:
                begin
                    l1_reg     <= ratio_val;
                    l1_sat_reg <= ratio_sat;
                end
                default:
                begin
                    l2_reg     <= ratio_val;
                    l2_sat_reg <= ratio_sat;
                end
            endcase
        end
        if (cmd.calc_diff)
            diff_reg <= (sref_reg >= strial_reg) ? sref_reg - strial_reg
                                                 : strial_reg - sref_reg;
        if (cmd.mul_diff)
            prod_reg <= sq_val;
        if (cmd.mul_ref)
        begin
            prod_reg   <= sq_val;
            sqdiff_reg <= prod_reg;
        end
        if (cmd.out_load)
            norm_reg <= '{l1_ratio: l1_reg, l2_ratio: l2_reg,
                          saturated: l1_sat_reg | l2_sat_reg};
    end

    // Running sums, wrap modulo 2^64, cleared when a result is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_abs_reg   <= '0;
            sum_sq_reg    <= '0;
            sum_ref_reg   <= '0;
            sum_refsq_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            sum_abs_reg   <= '0;
            sum_sq_reg    <= '0;
            sum_ref_reg   <= '0;
            sum_refsq_reg <= '0;
        end
        else if (cmd.accum)
        begin
            sum_abs_reg   <= sum_abs_reg + SUM_W'(diff_reg);
            sum_sq_reg    <= sum_sq_reg + SUM_W'(sqdiff_reg);
            sum_ref_reg   <= sum_ref_reg + SUM_W'(sref_reg);
            sum_refsq_reg <= sum_refsq_reg + SUM_W'(prod_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_valid_reg <= 1'b0;
        else if (cmd.out_load)
            norm_valid_reg <= 1'b1;
        else if (!norm_stall)
            norm_valid_reg <= 1'b0;
    end

    assign status.div_busy    = div_busy;
    assign status.div_done    = div_done;
    assign status.last_cell   = last_reg;
    assign status.out_blocked = norm_valid_reg && norm_stall;
    assign norm               = norm_reg;
    assign norm_valid         = norm_valid_reg;

endmodule

FILE: design/rsm_ctrl.sv
`timescale 1ns / 1ps

module rsm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_stall,
    input  rsm_pkg::rsm_status_t status,
    output rsm_pkg::rsm_cmd_t    cmd,
    output rsm_pkg::rsm_state_t  state
);
    import rsm_pkg::*;

    rsm_state_t state_reg;
    rsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (cell_valid) state_next = S_DIV_REF;
            S_DIV_REF:    state_next = S_WAIT_REF;
            S_WAIT_REF:   if (status.div_done) state_next = S_DIV_TRIAL;
            S_DIV_TRIAL:  state_next = S_WAIT_TRIAL;
            S_WAIT_TRIAL: if (status.div_done) state_next = S_DIFF;
            S_DIFF:       state_next = S_MUL_DIFF;
            S_MUL_DIFF:   state_next = S_MUL_REF;
            S_MUL_REF:    state_next = S_ACCUM;
            S_ACCUM:      state_next = status.last_cell ? S_DIV_L1 : S_IDLE;
            S_DIV_L1:     state_next = S_WAIT_L1;
            S_WAIT_L1:    if (status.div_done) state_next = S_DIV_L2;
            S_DIV_L2:     state_next = S_WAIT_L2;
            S_WAIT_L2:    if (status.div_done) state_next = S_OUT;
            S_OUT:        if (!status.out_blocked) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_REF;
        cell_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cell_stall    = 1'b0;
                cmd.load_cell = cell_valid;
            end
            S_DIV_REF:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_REF;
            end
            S_DIV_TRIAL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TRIAL;
            end
            S_DIV_L1:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_L1;
            end
            S_DIV_L2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_L2;
            end
            S_WAIT_REF, S_WAIT_TRIAL, S_WAIT_L1, S_WAIT_L2:
                cmd.cap_quot = status.div_done;
            S_DIFF:     cmd.calc_diff = 1'b1;
            S_MUL_DIFF: cmd.mul_diff  = 1'b1;
            S_MUL_REF:  cmd.mul_ref   = 1'b1;
            S_ACCUM:    cmd.accum     = 1'b1;
            S_OUT:      cmd.out_load  = !status.out_blocked;
            default:    cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule
